// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl of the point frame receiver
// no dependencies; each macro compiles to nothing when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/pfr_pkg.sv =====
// shared types and constants of the point frame receiver
// no dependencies; imported by point_frame_receiver_unit
package pfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int EV_W        = 3;
  localparam int IDX_W       = 4;
  localparam int CNT_OUT_W   = 5;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int MAX_PAYLOAD_DEF = 254;

  // framing and command bytes
  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'hFE;
  localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_STORE    = 8'hBB;
  localparam logic [BYTE_W-1:0] CMD_ALL      = 8'hCC;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 3'd0,
    EV_CLEARED  = 3'd1,
    EV_STORED   = 3'd2,
    EV_ALL      = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_UNKNOWN  = 3'd5,
    EV_FULL     = 3'd6
  } frame_ev_t;

endpackage

// ===== hdl/point_frame_receiver_unit.sv =====
// point frame receiver: header/trailer byte frame parser for point commands
// depends on pfr_pkg and assert_macros.svh
//
// channel | dir | word                    | handshake
// --------+-----+-------------------------+-------------------------
// in_     | in  | one received byte       | in_tvalid / in_tready
// out_    | out | event + point + status  | out_tvalid / out_tready
//
// every accepted byte gives exactly one result word in the result register
// one byte per cycle while out_tready is high: frame state updates in a single pass,
//   the result register is the only stage, and it refills in the cycle it drains
// in_tready is low only while a result waits and out_tready is low
// rst_n is synchronous, active low; it returns the parser to header search,
//   clears the point count and the all-points flag
`include "assert_macros.svh"

module point_frame_receiver_unit
  import pfr_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,   // 1 .. 256
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF   // 3 .. 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [3:0] point_index, [11:4] point_a, [19:12] point_b,
                                   // [24:20] point_count, [25] all_points, [31:26] zero
  output logic [2:0]  out_tuser    // [2:0] frame_event
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PCNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0]  MAX_PTS_C = CNT_W'(MAX_POINTS);
  localparam logic [PCNT_W-1:0] MAX_PAY_C = PCNT_W'(MAX_PAYLOAD);

  // frame state
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] op_a_r, op_a_nxt;
  logic [BYTE_W-1:0] op_b_r, op_b_nxt;
  logic [PCNT_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [PCNT_W-1:0] pay_cnt_inc;
  // point state
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              all_r, all_nxt;

  // result register
  logic              out_valid_r;
  frame_ev_t         out_ev_r, ev_nxt;
  logic [IDX_W-1:0]  out_idx_r, idx_nxt;
  logic [BYTE_W-1:0] out_a_r, a_nxt;
  logic [BYTE_W-1:0] out_b_r, b_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic              out_all_r;

  logic              in_fire;
  logic [CNT_W+IDX_W-1:0]     idx_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  // skid-free single stage: take a byte whenever the result slot frees up
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign pay_cnt_inc = pay_cnt_r + PCNT_W'(1);
  // index and count reported masked to their field widths
  assign idx_ext = {{IDX_W{1'b0}}, held_r};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, held_nxt};

  always_comb begin
    in_frame_nxt = in_frame_r;
    cmd_nxt      = cmd_r;
    op_a_nxt     = op_a_r;
    op_b_nxt     = op_b_r;
    pay_cnt_nxt  = pay_cnt_r;
    held_nxt     = held_r;
    all_nxt      = all_r;
    ev_nxt       = EV_NONE;
    idx_nxt      = '0;
    a_nxt        = '0;
    b_nxt        = '0;

    if (!in_frame_r) begin
      // header search: everything but the header is dropped
      if (in_tdata == HEADER_BYTE) begin
        in_frame_nxt = 1'b1;
      end
    end else if (in_tdata == TRAILER_BYTE) begin
      // end of frame: run the command, then back to header search
      unique case (cmd_r)
        CMD_CLEAR: begin
          held_nxt = '0;
          ev_nxt   = EV_CLEARED;
        end
        CMD_STORE: begin
          if (held_r < MAX_PTS_C) begin
            idx_nxt  = idx_ext[IDX_W-1:0];
            a_nxt    = op_a_r;
            b_nxt    = op_b_r;
            held_nxt = held_r + CNT_W'(1);
            ev_nxt   = EV_STORED;
          end else begin
            ev_nxt   = EV_FULL;
          end
        end
        CMD_ALL: begin
          all_nxt = 1'b1;
          ev_nxt  = EV_ALL;
        end
        default: begin
          ev_nxt = EV_UNKNOWN;
        end
      endcase
      in_frame_nxt = 1'b0;
      cmd_nxt      = '0;
      op_a_nxt     = '0;
      op_b_nxt     = '0;
      pay_cnt_nxt  = '0;
    end else begin
      // payload byte: keep the first three, count them all
      priority if (pay_cnt_r == PCNT_W'(0)) begin
        cmd_nxt = in_tdata;
      end else if (pay_cnt_r == PCNT_W'(1)) begin
        op_a_nxt = in_tdata;
      end else if (pay_cnt_r == PCNT_W'(2)) begin
        op_b_nxt = in_tdata;
      end else begin
        cmd_nxt = cmd_r;
      end
      if (pay_cnt_inc >= MAX_PAY_C) begin
        // runaway frame: drop it
        in_frame_nxt = 1'b0;
        cmd_nxt      = '0;
        op_a_nxt     = '0;
        op_b_nxt     = '0;
        pay_cnt_nxt  = '0;
        ev_nxt       = EV_OVERFLOW;
      end else begin
        pay_cnt_nxt  = pay_cnt_inc;
      end
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      cmd_r       <= '0;
      op_a_r      <= '0;
      op_b_r      <= '0;
      pay_cnt_r   <= '0;
      held_r      <= '0;
      all_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_frame_r <= in_frame_nxt;
        cmd_r      <= cmd_nxt;
        op_a_r     <= op_a_nxt;
        op_b_r     <= op_b_nxt;
        pay_cnt_r  <= pay_cnt_nxt;
        held_r     <= held_nxt;
        all_r      <= all_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ev_r  <= ev_nxt;
      out_idx_r <= idx_nxt;
      out_a_r   <= a_nxt;
      out_b_r   <= b_nxt;
      out_cnt_r <= cnt_ext[CNT_OUT_W-1:0];
      out_all_r <= all_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {6'b0, out_all_r, out_cnt_r, out_b_r, out_a_r, out_idx_r};

  `ASSERT_ALWAYS(a_held_bound, clk, rst_n, held_r <= MAX_PTS_C, "point count above limit")
  `ASSERT_ALWAYS(a_pay_bound, clk, rst_n, pay_cnt_r < MAX_PAY_C, "payload count at limit")
  `ASSERT_ALWAYS(a_idle_clean, clk, rst_n,
    in_frame_r || (pay_cnt_r == '0 && cmd_r == '0 && op_a_r == '0 && op_b_r == '0),
    "frame state not cleared outside a frame")
  `ASSERT_NEXT(a_store_counts, clk, rst_n, in_fire && ev_nxt == EV_STORED,
    held_r == $past(held_r) + CNT_W'(1) && out_ev_r == EV_STORED, "store did not count")
  `ASSERT_NEXT(a_sticky_all, clk, rst_n, all_r && !(in_fire && !rst_n), all_r,
    "all-points flag dropped")

endmodule
